// ----- sv/arat_pkg.sv -----
// Shared constants and types for the address range translation table.
`default_nettype none
package arat_pkg;

   localparam int REGION_SLOTS = 16;
   localparam int ADDR_W       = 64;
   localparam int SLOT_W       = 4;
   localparam int OP_W         = 2;
   localparam int IDX_W        = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
   localparam int CNT_W        = $clog2(REGION_SLOTS + 1);
   localparam int RANGE_W      = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

   localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE     = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [IDX_W-1:0]  idx_type;

   // Table update broadcast to every cell.
   typedef struct packed {
      logic     write_en;
      logic     clear;
      slot_type slot;
      addr_type base;
      addr_type limit;
      addr_type target;
   } update_type;

   // Lookup travelling down the cell chain with the best candidate so far.
   typedef struct packed {
      logic     valid;
      addr_type addr;
      logic     found;
      addr_type base;
      addr_type limit;
      addr_type target;
   } sweep_type;

endpackage
`default_nettype wire

// ----- sv/arat_req_if.sv -----
// Request channel carrying one table operation per beat.
`default_nettype none
interface arat_req_if
   import arat_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic [OP_W-1:0] opcode;
   slot_type        slot;
   addr_type        address;
   addr_type        region_limit;
   addr_type        region_target;

   modport source (output valid, opcode, slot, address, region_limit, region_target,
                   input ready);
   modport sink   (input valid, opcode, slot, address, region_limit, region_target,
                   output ready);
endinterface
`default_nettype wire

// ----- sv/arat_rsp_if.sv -----
// Response channel carrying one result per beat.
`default_nettype none
interface arat_rsp_if
   import arat_pkg::*;
   ();
   logic     valid;
   logic     ready;
   addr_type result_address;
   logic     hit;
   logic     write_rejected;

   modport source (output valid, result_address, hit, write_rejected, input ready);
   modport sink   (input valid, result_address, hit, write_rejected, output ready);
endinterface
`default_nettype wire

// ----- sv/arat_cell.sv -----
// One table slot that holds a region and refines a passing lookup.
`default_nettype none
module arat_cell
   import arat_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  idx_type    cell_index,
   input  update_type update,
   input  sweep_type  sweep_in,
   output sweep_type  sweep_out
);

   logic      valid_ff;
   addr_type  base_ff;
   addr_type  limit_ff;
   addr_type  target_ff;
   sweep_type sweep_ff;
   sweep_type sweep_in_w;
   logic      selected;
   logic      take;

   assign selected = update.write_en &&
                     (RANGE_W'(update.slot) == RANGE_W'(cell_index));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (update.clear) begin
         valid_ff <= 1'b0;
      end else if (selected) begin
         valid_ff <= (update.limit >= update.base);
      end
   end

   always_ff @(posedge clock) begin
      if (selected) begin
         base_ff   <= update.base;
         limit_ff  <= update.limit;
         target_ff <= update.target;
      end
   end

   // Later cells win ties, so an equal base replaces the candidate.
   assign take = valid_ff && (base_ff <= sweep_in.addr) &&
                 (!sweep_in.found || (base_ff >= sweep_in.base));

   always_comb begin
      sweep_in_w = sweep_in;
      if (take) begin
         sweep_in_w.found  = 1'b1;
         sweep_in_w.base   = base_ff;
         sweep_in_w.limit  = limit_ff;
         sweep_in_w.target = target_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff.valid <= 1'b0;
      end else begin
         sweep_ff.valid <= sweep_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      sweep_ff.addr   <= sweep_in_w.addr;
      sweep_ff.found  <= sweep_in_w.found;
      sweep_ff.base   <= sweep_in_w.base;
      sweep_ff.limit  <= sweep_in_w.limit;
      sweep_ff.target <= sweep_in_w.target;
   end

   assign sweep_out = sweep_ff;

endmodule
`default_nettype wire

// ----- sv/address_range_translate_table_core.sv -----
// Top level of the address range translation table.
// The block handles one request at a time. A write or clear beat is applied at
// acceptance and its result goes into the pending register; a translate beat
// walks the chain of REGION_SLOTS slot cells, one cell per cycle starting at
// the accepting edge, then registers the range check in the pending register.
// From there the final add is loaded into the output register once that is
// free. The next request is taken as soon as the previous response has moved
// into the output register, even while that response is still waiting to be
// taken. Slot valid bits clear at reset.
`default_nettype none
module address_range_translate_table_core
   import arat_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   arat_req_if.sink    req_bus,
   arat_rsp_if.source  rsp_bus
);

   logic       busy_ff;
   logic       busy_in;
   logic       pend_valid_ff;
   logic       pend_valid_in;
   logic       pend_in_range_ff;
   addr_type   pend_diff_ff;
   addr_type   pend_target_ff;
   addr_type   pend_addr_ff;
   logic       pend_rejected_ff;
   logic       rsp_valid_ff;
   addr_type   rsp_addr_ff;
   logic       rsp_hit_ff;
   logic       rsp_rejected_ff;
   logic       accept;
   logic       out_free;
   logic       pend_move;
   logic       is_translate;
   logic       is_write;
   logic       slot_ok;
   update_type update;
   sweep_type  chain [REGION_SLOTS+1];
   logic [REGION_SLOTS-1:0] sweep_busy;

   assign req_bus.ready = !busy_ff;
   assign accept        = req_bus.valid && !busy_ff;
   assign is_translate  = (req_bus.opcode == OP_TRANSLATE);
   assign is_write      = (req_bus.opcode == OP_WRITE);
   assign slot_ok       = RANGE_W'(req_bus.slot) < RANGE_W'(REGION_SLOTS);

   assign update.write_en = accept && is_write && slot_ok;
   assign update.clear    = accept && (req_bus.opcode == OP_CLEAR);
   assign update.slot     = req_bus.slot;
   assign update.base     = req_bus.address;
   assign update.limit    = req_bus.region_limit;
   assign update.target   = req_bus.region_target;

   always_comb begin
      chain[0].valid  = accept && is_translate;
      chain[0].addr   = req_bus.address;
      chain[0].found  = 1'b0;
      chain[0].base   = '0;
      chain[0].limit  = '0;
      chain[0].target = '0;
   end

   for (genvar gi = 0; gi < REGION_SLOTS; gi++) begin : g_cell
      arat_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(gi)),
         .update     (update),
         .sweep_in   (chain[gi]),
         .sweep_out  (chain[gi+1])
      );
      assign sweep_busy[gi] = chain[gi+1].valid;
   end

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign pend_move = pend_valid_ff && out_free;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (pend_move) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if ((accept && !is_translate) || chain[REGION_SLOTS].valid) begin
         pend_valid_in = 1'b1;
      end else if (pend_move) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
         if (pend_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !is_translate) begin
         pend_in_range_ff <= 1'b0;
         pend_diff_ff     <= '0;
         pend_target_ff   <= '0;
         pend_addr_ff     <= '0;
         pend_rejected_ff <= is_write && slot_ok &&
                             (req_bus.region_limit < req_bus.address);
      end else if (chain[REGION_SLOTS].valid) begin
         pend_in_range_ff <= chain[REGION_SLOTS].found &&
                             (chain[REGION_SLOTS].addr < chain[REGION_SLOTS].limit);
         pend_diff_ff     <= chain[REGION_SLOTS].addr - chain[REGION_SLOTS].base;
         pend_target_ff   <= chain[REGION_SLOTS].target;
         pend_addr_ff     <= chain[REGION_SLOTS].addr;
         pend_rejected_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_move) begin
         rsp_addr_ff     <= pend_in_range_ff ? (pend_target_ff + pend_diff_ff)
                                             : pend_addr_ff;
         rsp_hit_ff      <= pend_in_range_ff;
         rsp_rejected_ff <= pend_rejected_ff;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.result_address = rsp_addr_ff;
   assign rsp_bus.hit            = rsp_hit_ff;
   assign rsp_bus.write_rejected = rsp_rejected_ff;

   // At most one lookup is ever in the chain.
   assert property (@(posedge clock) disable iff (reset) $onehot0(sweep_busy))
      else $error("more than one lookup in the cell chain");

   // A lookup in flight means the block is holding its request.
   assert property (@(posedge clock) disable iff (reset) (|sweep_busy) |-> busy_ff)
      else $error("lookup in the chain while idle");

   // A pending result always belongs to an outstanding request.
   assert property (@(posedge clock) disable iff (reset) pend_valid_ff |-> busy_ff)
      else $error("pending result without an outstanding request");

   // A lookup and a pending result never coexist.
   assert property (@(posedge clock) disable iff (reset)
                    pend_valid_ff |-> !(|sweep_busy))
      else $error("pending result while the chain is still busy");

   // A hit and a rejected write cannot come from the same beat.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff |-> !(rsp_hit_ff && rsp_rejected_ff))
      else $error("response flags both hit and write rejection");

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the address range translation table core.
module tb_top;
   import arat_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam addr_type ADDR_MAX = '1;
   localparam int RANDOM_OPS = 2000;
   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      slot_type        slot;
      addr_type        address;
      addr_type        region_limit;
      addr_type        region_target;
      logic            typed;
      addr_type        exp_address;
      logic            exp_hit;
      logic            exp_rejected;
   } table_op_type;

   typedef struct packed {
      addr_type result_address;
      logic     hit;
      logic     write_rejected;
   } lookup_result_type;

   logic clock;
   logic reset;

   arat_req_if req_bus ();
   arat_rsp_if rsp_bus ();

   address_range_translate_table_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic     entry_valid [REGION_SLOTS] = '{default: 1'b0};
   addr_type entry_base [REGION_SLOTS];
   addr_type entry_end [REGION_SLOTS];
   addr_type entry_offset [REGION_SLOTS];

   addr_type plan_base [REGION_SLOTS] = '{default: '0};
   addr_type plan_end [REGION_SLOTS] = '{default: '0};
   addr_type high_window;

   table_op_type      offered_ops[$];
   lookup_result_type awaited_results[$];
   int                error_count = 0;
   int                quiet_cycles = 0;
   int                burst_left = 0;

   table_op_type directed_ops [25] = '{
      '{OP_TRANSLATE, 4'd0, 64'h0, 64'h0, 64'h0, 1'b1, 64'h0, 1'b0, 1'b0},
      '{OP_TRANSLATE, 4'd15, ADDR_MAX, ADDR_MAX, ADDR_MAX, 1'b1, ADDR_MAX, 1'b0, 1'b0},
      '{OP_WRITE, 4'd0, 64'h0, 64'h1000, 64'h8000_0000, 1'b1, 64'h0, 1'b0, 1'b0},
      '{OP_TRANSLATE, 4'd0, 64'h10, 64'h0, 64'h0, 1'b1, 64'h8000_0010, 1'b1, 1'b0},
      '{OP_TRANSLATE, 4'd0, 64'h1000, 64'h0, 64'h0, 1'b1, 64'h1000, 1'b0, 1'b0},
      '{OP_WRITE, 4'd15, 64'h1000, 64'h0FFF, 64'h5555, 1'b1, 64'h0, 1'b0, 1'b1},
      '{OP_TRANSLATE, 4'd0, 64'h1000, 64'h0, 64'h0, 1'b1, 64'h1000, 1'b0, 1'b0},
      '{OP_WRITE, 4'd15, 64'hFFFF_FFFF_FFFF_F000, ADDR_MAX, ADDR_MAX,
        1'b1, 64'h0, 1'b0, 1'b0},
      '{OP_TRANSLATE, 4'd0, 64'hFFFF_FFFF_FFFF_F001, 64'h0, 64'h0,
        1'b1, 64'h0, 1'b1, 1'b0},
      '{OP_TRANSLATE, 4'd0, ADDR_MAX, 64'h0, 64'h0, 1'b1, ADDR_MAX, 1'b0, 1'b0},
      '{OP_WRITE, 4'd3, 64'h2000, 64'h2000, 64'hABCD, 1'b1, 64'h0, 1'b0, 1'b0},
      '{OP_TRANSLATE, 4'd0, 64'h2000, 64'h0, 64'h0, 1'b1, 64'h2000, 1'b0, 1'b0},
      '{OP_WRITE, 4'd5, 64'h3000, 64'h4000, 64'h10_0000, 1'b1, 64'h0, 1'b0, 1'b0},
      '{OP_WRITE, 4'd9, 64'h3000, 64'h5000, 64'h20_0000, 1'b1, 64'h0, 1'b0, 1'b0},
      '{OP_TRANSLATE, 4'd0, 64'h4800, 64'h0, 64'h0, 1'b1, 64'h20_1800, 1'b1, 1'b0},
      '{OP_TRANSLATE, 4'd0, 64'h3001, 64'h0, 64'h0, 1'b1, 64'h20_0001, 1'b1, 1'b0},
      '{OP_UNUSED, 4'd7, 64'hDEAD_BEEF_0123_4567, 64'h0, ADDR_MAX,
        1'b1, 64'h0, 1'b0, 1'b0},
      '{OP_WRITE, 4'd9, 64'h3000, 64'h2FFF, 64'h0, 1'b1, 64'h0, 1'b0, 1'b1},
      '{OP_TRANSLATE, 4'd0, 64'h3004, 64'h0, 64'h0, 1'b1, 64'h10_0004, 1'b1, 1'b0},
      '{OP_WRITE, 4'd0, ADDR_MAX, ADDR_MAX, 64'h0, 1'b1, 64'h0, 1'b0, 1'b0},
      '{OP_TRANSLATE, 4'd0, 64'h10, 64'h0, 64'h0, 1'b1, 64'h10, 1'b0, 1'b0},
      '{OP_CLEAR, 4'd0, 64'h0, 64'h0, 64'h0, 1'b1, 64'h0, 1'b0, 1'b0},
      '{OP_TRANSLATE, 4'd0, 64'h3004, 64'h0, 64'h0, 1'b1, 64'h3004, 1'b0, 1'b0},
      '{OP_WRITE, 4'd1, 64'h0123_4567_89AB_CDEF, 64'h0123_4567_8A00_0000,
        64'hFEDC_BA98_7654_3210, 1'b0, 64'h0, 1'b0, 1'b0},
      '{OP_TRANSLATE, 4'd0, 64'h0123_4567_89FF_0000, 64'h0, 64'h0,
        1'b0, 64'h0, 1'b0, 1'b0}
   };

   function automatic addr_type rand_word();
      return {$urandom, $urandom};
   endfunction

   // Applies one operation to the shadow table and returns the result it should produce.
   function automatic lookup_result_type table_outcome(table_op_type op);
      lookup_result_type res;
      logic              found;
      int                best;
      res = '0;
      found = 1'b0;
      best = 0;
      case (op.opcode)
         OP_TRANSLATE: begin
            for (int i = 0; i < REGION_SLOTS; i++) begin
               if (entry_valid[i] && entry_base[i] <= op.address) begin
                  if (!found || entry_base[i] >= entry_base[best]) begin
                     best = i;
                     found = 1'b1;
                  end
               end
            end
            if (found && op.address < entry_end[best]) begin
               res.result_address = entry_offset[best] + (op.address - entry_base[best]);
               res.hit = 1'b1;
            end else begin
               res.result_address = op.address;
            end
         end
         OP_WRITE: begin
            if (op.region_limit < op.address) begin
               entry_valid[op.slot] = 1'b0;
               res.write_rejected = 1'b1;
            end else begin
               entry_base[op.slot] = op.address;
               entry_end[op.slot] = op.region_limit;
               entry_offset[op.slot] = op.region_target;
               entry_valid[op.slot] = 1'b1;
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < REGION_SLOTS; i++) begin
               entry_valid[i] = 1'b0;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Mostly writes of overlapping regions and lookups aimed at their edges and insides.
   function automatic table_op_type draw_table_op();
      table_op_type op;
      int           pick;
      int           s;
      addr_type     span;
      op = '0;
      op.opcode = OP_TRANSLATE;
      op.slot = slot_type'($urandom_range(0, 15));
      op.address = rand_word();
      op.region_limit = rand_word();
      op.region_target = rand_word();
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         op.opcode = OP_CLEAR;
      end else if (pick < 5) begin
         op.opcode = OP_UNUSED;
      end else if (pick < 35) begin
         op.opcode = OP_WRITE;
         case ($urandom_range(0, 7))
            0: begin
            end
            1: op.address = '0;
            2: op.address = ADDR_MAX - addr_type'($urandom_range(0, 4095));
            3: op.address = plan_base[$urandom_range(0, REGION_SLOTS - 1)];
            default: begin
               op.address = addr_type'($urandom_range(0, 63)) << 12;
               if ($urandom_range(0, 1) == 1) op.address = op.address | high_window;
            end
         endcase
         case ($urandom_range(0, 9))
            0: span = '0;
            1: span = ADDR_MAX;
            2: span = rand_word();
            default: span = addr_type'($urandom_range(1, 32'h8000));
         endcase
         if (op.address + span < op.address) begin
            op.region_limit = ADDR_MAX;
         end else begin
            op.region_limit = op.address + span;
         end
         if ($urandom_range(0, 9) == 0 && op.address != '0) begin
            op.region_limit = op.address - 1;
            if (op.address > 256) begin
               op.region_limit = op.region_limit - addr_type'($urandom_range(0, 255));
            end
         end
         if ($urandom_range(0, 1) == 1) op.region_target = addr_type'($urandom) << 12;
         plan_base[op.slot] = op.address;
         plan_end[op.slot] = op.region_limit;
      end else begin
         case ($urandom_range(0, 9))
            0: begin
            end
            1: op.address = ($urandom_range(0, 1) == 1) ? ADDR_MAX : '0;
            default: begin
               s = $urandom_range(0, REGION_SLOTS - 1);
               span = plan_end[s] - plan_base[s];
               case ($urandom_range(0, 3))
                  0: op.address = plan_base[s];
                  1: op.address = plan_end[s] - 1;
                  2: op.address = plan_end[s];
                  default: begin
                     if (span == ADDR_MAX) begin
                        op.address = rand_word();
                     end else begin
                        op.address = plan_base[s] + rand_word() % (span + 1);
                     end
                  end
               endcase
            end
         endcase
      end
      return op;
   endfunction

   task automatic send_op(input table_op_type op);
      int gap;
      if (burst_left == 0) begin
         req_bus.valid = 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      offered_ops = {offered_ops, op};
      req_bus.valid = 1'b1;
      req_bus.opcode = op.opcode;
      req_bus.slot = op.slot;
      req_bus.address = op.address;
      req_bus.region_limit = op.region_limit;
      req_bus.region_target = op.region_target;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_bus.valid = 1'b0;
      while (offered_ops.size() != 0 || awaited_results.size() != 0) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : sender
      table_op_type op;
      int           issued;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_TRANSLATE;
      req_bus.slot = '0;
      req_bus.address = '0;
      req_bus.region_limit = '0;
      req_bus.region_target = '0;
      high_window = rand_word() & (ADDR_MAX << 20);
      issued = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed_ops[i]) send_op(directed_ops[i]);
      wait_for_results();
      while (issued < RANDOM_OPS) begin
         op = draw_table_op();
         if (op.opcode != OP_UNUSED) issued++;
         if (issued == RANDOM_OPS / 2) wait_for_results();
         send_op(op);
      end
      wait_for_results();
      repeat (REGION_SLOTS + 4) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : receiver
      int stall_left;
      int mode;
      int mode_left;
      int tick;
      stall_left = 0;
      mode = 0;
      mode_left = 0;
      tick = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 400);
         end
         mode_left--;
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            case (mode)
               0: rsp_bus.ready = 1'b1;
               1: rsp_bus.ready = ($urandom_range(0, 2) != 0);
               2: begin
                  if ($urandom_range(0, 15) == 0) begin
                     stall_left = $urandom_range(0, 19);
                     rsp_bus.ready = 1'b0;
                  end else begin
                     rsp_bus.ready = 1'b1;
                  end
               end
               default: rsp_bus.ready = (tick % 3 != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : monitor
      table_op_type      op;
      lookup_result_type want;
      if (!reset) begin
         quiet_cycles++;
         if (req_bus.valid && req_bus.ready) begin
            quiet_cycles = 0;
            op = offered_ops.pop_front();
            want = table_outcome(op);
            if (op.typed) want = '{op.exp_address, op.exp_hit, op.exp_rejected};
            awaited_results = {awaited_results, want};
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            quiet_cycles = 0;
            if (awaited_results.size() == 0) begin
               $error("response beat with no request outstanding");
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_bus.result_address !== want.result_address) begin
                  $error("result_address: expected %h, got %h",
                         want.result_address, rsp_bus.result_address);
                  error_count++;
               end
               if (rsp_bus.hit !== want.hit) begin
                  $error("hit: expected %b, got %b", want.hit, rsp_bus.hit);
                  error_count++;
               end
               if (rsp_bus.write_rejected !== want.write_rejected) begin
                  $error("write_rejected: expected %b, got %b",
                         want.write_rejected, rsp_bus.write_rejected);
                  error_count++;
               end
            end
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $error("no beat accepted for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

endmodule
